/* hw/rtl/tagged_chunk_segmenter_defines.svh */
// Assertion macros for the tagged chunk segmenter
`ifndef TAGGED_CHUNK_SEGMENTER_DEFINES_SVH
`define TAGGED_CHUNK_SEGMENTER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every clock edge out of reset
`define TCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcs assertion failed");
// Next-cycle implication, checked on every clock edge out of reset
`define TCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcs assertion failed");
`else
`define TCS_ASSERT_IMPL(lbl, ante, cons)
`define TCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/tcs_pkg.sv */
// Shared types and constants for the tagged chunk segmenter
package tcs_pkg;

  localparam int unsigned MAX_BEATS  = 5;
  localparam int unsigned BEAT_CNT_W = $clog2(MAX_BEATS + 1);
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [9:0]  MIN_MTU       = 10'd23;
  localparam logic [9:0]  LINK_OVERHEAD = 10'd4;
  localparam logic [16:0] HEADER_BYTES  = 17'd3;

  typedef enum logic [2:0] {
    REG_PEER_CONNECTED = 3'd0,
    REG_LINK_MTU       = 3'd1,
    REG_TAG_FIRST      = 3'd2,
    REG_TAG_CONTINUE   = 3'd3,
    REG_TAG_FINAL      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       peer_connected;
    logic [9:0] link_mtu;
    logic [7:0] tag_first;
    logic [7:0] tag_continue;
    logic [7:0] tag_final;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_begin;
    logic       chunk_finish;
    logic       message_finish;
  } beat_t;

  // All output beats caused by one input item
  typedef struct packed {
    beat_t [MAX_BEATS-1:0]  beats;
    logic [BEAT_CNT_W-1:0]  count;
  } rec_t;

endpackage

/* hw/rtl/tcs_front.sv */
// Front end: accepts items, tracks framing state and builds beat records
module tcs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  tcs_pkg::cfg_t cfg,
  input  logic          acc,
  input  logic          message_start,
  input  logic [7:0]    msg_kind,
  input  logic [15:0]   payload_length,
  input  logic          byte_present,
  input  logic [7:0]    payload_byte,
  output logic          push,
  output tcs_pkg::rec_t rec
);

  logic [16:0] frame_offset_r, frame_offset_nxt;
  logic [16:0] frame_total_r, frame_total_nxt;
  logic [9:0]  chunk_fill_r, chunk_fill_nxt;
  logic        in_message_r, in_message_nxt;

  logic [9:0]  mtu_eff;
  logic [9:0]  seg_limit;
  logic [16:0] remaining;
  logic [16:0] offset_inc;
  logic [9:0]  fill_inc;
  logic        msg_done;
  logic        chunk_done;
  logic [7:0]  mid_tag;
  logic        plen_empty;
  logic        plen_one;

  always_comb begin
    mtu_eff    = (cfg.link_mtu < tcs_pkg::MIN_MTU) ? tcs_pkg::MIN_MTU : cfg.link_mtu;
    seg_limit  = mtu_eff - tcs_pkg::LINK_OVERHEAD;
    remaining  = frame_total_r - frame_offset_r;
    mid_tag    = (remaining <= {7'd0, seg_limit}) ? cfg.tag_final : cfg.tag_continue;
    offset_inc = frame_offset_r + 17'd1;
    fill_inc   = chunk_fill_r + 10'd1;
    msg_done   = (offset_inc >= frame_total_r);
    chunk_done = msg_done || (fill_inc >= seg_limit);
    plen_empty = (payload_length == 16'd0);
    plen_one   = (payload_length == 16'd1);
  end

  always_comb begin
    rec              = '0;
    frame_offset_nxt = frame_offset_r;
    frame_total_nxt  = frame_total_r;
    chunk_fill_nxt   = chunk_fill_r;
    in_message_nxt   = in_message_r;
    if (acc) begin
      if (!cfg.peer_connected) begin
        // drop the item and abandon any message in flight
        frame_offset_nxt = '0;
        frame_total_nxt  = '0;
        chunk_fill_nxt   = '0;
        in_message_nxt   = 1'b0;
      end else if (message_start) begin
        // header always fits in the first chunk since seg_limit is at least 19
        rec.beats[0]     = '{data: cfg.tag_first, chunk_begin: 1'b1,
                             chunk_finish: 1'b0, message_finish: 1'b0};
        rec.beats[1]     = '{data: msg_kind, chunk_begin: 1'b0,
                             chunk_finish: 1'b0, message_finish: 1'b0};
        rec.beats[2]     = '{data: payload_length[7:0], chunk_begin: 1'b0,
                             chunk_finish: 1'b0, message_finish: 1'b0};
        rec.beats[3]     = '{data: payload_length[15:8], chunk_begin: 1'b0,
                             chunk_finish: plen_empty, message_finish: plen_empty};
        rec.count        = tcs_pkg::BEAT_CNT_W'(4);
        frame_total_nxt  = tcs_pkg::HEADER_BYTES + {1'b0, payload_length};
        frame_offset_nxt = tcs_pkg::HEADER_BYTES;
        chunk_fill_nxt   = 10'd3;
        in_message_nxt   = 1'b1;
        if (plen_empty) begin
          chunk_fill_nxt = '0;
          in_message_nxt = 1'b0;
        end else if (byte_present) begin
          rec.beats[4]     = '{data: payload_byte, chunk_begin: 1'b0,
                               chunk_finish: plen_one, message_finish: plen_one};
          rec.count        = tcs_pkg::BEAT_CNT_W'(5);
          frame_offset_nxt = 17'd4;
          chunk_fill_nxt   = plen_one ? 10'd0 : 10'd4;
          in_message_nxt   = !plen_one;
        end
      end else if (in_message_r && byte_present) begin
        if (chunk_fill_r == 10'd0) begin
          rec.beats[0] = '{data: mid_tag, chunk_begin: 1'b1,
                           chunk_finish: 1'b0, message_finish: 1'b0};
          rec.beats[1] = '{data: payload_byte, chunk_begin: 1'b0,
                           chunk_finish: chunk_done, message_finish: msg_done};
          rec.count    = tcs_pkg::BEAT_CNT_W'(2);
        end else begin
          rec.beats[0] = '{data: payload_byte, chunk_begin: 1'b0,
                           chunk_finish: chunk_done, message_finish: msg_done};
          rec.count    = tcs_pkg::BEAT_CNT_W'(1);
        end
        frame_offset_nxt = offset_inc;
        chunk_fill_nxt   = chunk_done ? 10'd0 : fill_inc;
        in_message_nxt   = !msg_done;
      end
    end
    push = acc && (rec.count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_offset_r <= '0;
      frame_total_r  <= '0;
      chunk_fill_r   <= '0;
      in_message_r   <= 1'b0;
    end else begin
      frame_offset_r <= frame_offset_nxt;
      frame_total_r  <= frame_total_nxt;
      chunk_fill_r   <= chunk_fill_nxt;
      in_message_r   <= in_message_nxt;
    end
  end

endmodule

/* hw/rtl/tcs_queue.sv */
// Short record queue between the front end and the beat serializer
module tcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcs_pkg::rec_t push_rec,
  input  logic          pop,
  output tcs_pkg::rec_t head,
  output logic          not_empty,
  output logic          full
);

  tcs_pkg::rec_t                mem_r [tcs_pkg::QDEPTH];
  logic [tcs_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tcs_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tcs_pkg::QCNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    full       = (count_r == tcs_pkg::QCNT_W'(tcs_pkg::QDEPTH));
    not_empty  = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcs_pkg::QPTR_W'(tcs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcs_pkg::QPTR_W'(tcs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/tcs_back.sv */
// Back end: walks the head record one output beat at a time
module tcs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tcs_pkg::rec_t head,
  input  logic          head_valid,
  input  logic          out_ready,
  output logic          out_valid,
  output tcs_pkg::beat_t beat,
  output logic          run_last,
  output logic          pop
);

  logic [tcs_pkg::BEAT_CNT_W-1:0] idx_r, idx_nxt;
  logic                           fire;

  always_comb begin
    out_valid = head_valid;
    beat      = head.beats[idx_r];
    run_last  = (idx_r == head.count - 1'b1);
    fire      = out_valid && out_ready;
    pop       = fire && run_last;
    idx_nxt   = idx_r;
    if (fire) begin
      // advance within the record, rewind when it is done
      idx_nxt = run_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

/* hw/rtl/tagged_chunk_segmenter.sv */
// Top level: accepts one item per cycle while the record queue has room.
// Records are registered in the queue before their first beat shows on the output.
// Each item gives 1, 2, 4 or 5 beats, sent one per cycle while out_ready is high;
// single-beat items then stream at one per cycle, set by the one-beat back end.
// Reset (synchronous, active low): queue emptied, framing state cleared,
// registers return to peer off, MTU 23 and tags 1, 2, 3.
`include "tagged_chunk_segmenter_defines.svh"

module tagged_chunk_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_message_start,
  input  logic [7:0]  in_msg_kind,
  input  logic [15:0] in_payload_length,
  input  logic        in_byte_present,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_chunk_begin,
  output logic        out_chunk_finish,
  output logic        out_message_finish,
  output logic        out_run_last
);

  tcs_pkg::cfg_t  cfg_r;
  tcs_pkg::rec_t  push_rec;
  tcs_pkg::rec_t  head;
  tcs_pkg::beat_t beat;
  logic           push;
  logic           pop;
  logic           q_not_empty;
  logic           q_full;
  logic           in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peer_connected <= 1'b0;
      cfg_r.link_mtu       <= 10'd23;
      cfg_r.tag_first      <= 8'd1;
      cfg_r.tag_continue   <= 8'd2;
      cfg_r.tag_final      <= 8'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcs_pkg::REG_PEER_CONNECTED: cfg_r.peer_connected <= cfg_wdata[0];
        tcs_pkg::REG_LINK_MTU:       cfg_r.link_mtu       <= cfg_wdata;
        tcs_pkg::REG_TAG_FIRST:      cfg_r.tag_first      <= cfg_wdata[7:0];
        tcs_pkg::REG_TAG_CONTINUE:   cfg_r.tag_continue   <= cfg_wdata[7:0];
        tcs_pkg::REG_TAG_FINAL:      cfg_r.tag_final      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  tcs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .acc            (in_acc),
    .message_start  (in_message_start),
    .msg_kind       (in_msg_kind),
    .payload_length (in_payload_length),
    .byte_present   (in_byte_present),
    .payload_byte   (in_payload_byte),
    .push           (push),
    .rec            (push_rec)
  );

  tcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_not_empty),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .beat       (beat),
    .run_last   (out_run_last),
    .pop        (pop)
  );

  assign out_byte           = beat.data;
  assign out_chunk_begin    = beat.chunk_begin;
  assign out_chunk_finish   = beat.chunk_finish;
  assign out_message_finish = beat.message_finish;

  `TCS_ASSERT_IMPL(a_tag_not_finish, out_valid && out_chunk_begin, !out_chunk_finish && !out_message_finish)
  `TCS_ASSERT_IMPL(a_msg_ends_chunk, out_valid && out_message_finish, out_chunk_finish && out_run_last)
  `TCS_ASSERT_IMPL(a_stall_has_data, !in_ready, out_valid)
  `TCS_ASSERT_NEXT(a_push_shows, push, out_valid)

endmodule
